// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RQS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rqs assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define RQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rqs assertion failed");

`endif

// ----- design/rqs_pkg.sv -----
// Shared types, constants and datapath operation codes of the quicksort unit.
`timescale 1ns / 1ps
package rqs_pkg;

  localparam int unsigned KEY_W         = 32;
  localparam int unsigned CMP_W         = 11;
  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam logic [31:0] LFSR_TAPS     = 32'h8020_0003;
  localparam logic [31:0] SEED_RESET    = 32'h0000_0001;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_value;
    logic                    set_end;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic [CMP_W-1:0]        compare_total;
    logic                    dropped_flag;
    logic                    final_item;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_START,
    OP_POP,
    OP_RANGE,
    OP_SPLIT,
    OP_PICK,
    OP_SW_RD,
    OP_SW_WA,
    OP_SW_WB,
    OP_PART,
    OP_LOOP_RD,
    OP_LOOP_CMP,
    OP_LOOP_SW,
    OP_FIN,
    OP_PUSH_R,
    OP_PUSH_L,
    OP_EM_RD,
    OP_EM_OUT,
    OP_EM_NEXT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic depth_zero;
    logic range_ok;
    logic mod_done;
    logic j_at_high;
    logic swap_needed;
    logic emit_last;
    logic out_xfer;
  } dp_status_t;

endpackage

// ----- design/rqs_mod_unit.sv -----
// Bit-serial remainder unit: 32-bit dividend modulo a small range length.
`timescale 1ns / 1ps
module rqs_mod_unit #(
  parameter int unsigned MAX_ITEMS = rqs_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [31:0]                      dividend_i,
  input  logic [$clog2(MAX_ITEMS):0]       divisor_i,
  output logic [$clog2(MAX_ITEMS)-1:0]     rem_o,
  output logic                             done_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned RW    = IDX_W + 1;

  logic [RW-1:0] rem_q, rem_d, trial;
  logic [RW-1:0] div_q;
  logic [31:0]   dvd_q;
  logic [4:0]    step_q;
  logic          busy_q, done_q;

  // Shift in one dividend bit and subtract the divisor when it fits.
  assign trial = {rem_q[RW-2:0], dvd_q[31]};
  assign rem_d = (trial >= div_q) ? (trial - div_q) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[30:0], 1'b0};
    end
  end

  assign rem_o  = rem_q[IDX_W-1:0];
  assign done_o = done_q;

endmodule

// ----- design/rqs_datapath.sv -----
// Datapath: key store, range stack, LFSR, counters and the output register.
`timescale 1ns / 1ps
module rqs_datapath #(
  parameter int unsigned MAX_ITEMS = rqs_pkg::MAX_ITEMS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rqs_pkg::in_item_t   in_item_i,
  input  rqs_pkg::dp_cmd_t    cmd_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  output logic [31:0]         seed_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output rqs_pkg::out_item_t  out_item_o,
  output rqs_pkg::dp_status_t status_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned RW    = IDX_W + 1;
  localparam int unsigned KW    = rqs_pkg::KEY_W;
  localparam int unsigned CW    = rqs_pkg::CMP_W;

  // Memories.
  logic [KW-1:0]      keys [MAX_ITEMS];
  logic [2*IDX_W-1:0] stack [MAX_ITEMS];

  logic [CNT_W-1:0] fill_q, fill_d, depth_q, depth_d;
  logic             ovf_q, ovf_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [31:0]      lfsr_q, lfsr_d, lfsr_nxt, seed_q;
  logic             out_valid_q, out_valid_d;

  logic [IDX_W-1:0] low_q, high_q, j_q, place_q, sa_q, sb_q, k_q;
  logic [KW-1:0]    pivot_q, rd_a_q, rd_b_q;
  logic [2*IDX_W-1:0] stk_rd_q;
  rqs_pkg::out_item_t out_q;

  logic [CNT_W-1:0] fill_m1, depth_m1;
  logic             room, stk_room, le, swap_needed, emit_last, out_xfer;
  logic             push_r_ok, push_l_ok;
  logic [RW-1:0]    len;
  logic [IDX_W-1:0] rem;
  logic             mod_done;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra, mem_rb;
  logic [KW-1:0]    mem_wd;
  logic             stk_we;
  logic [IDX_W-1:0] stk_wa;
  logic [2*IDX_W-1:0] stk_wd;

  assign fill_m1   = fill_q - CNT_W'(1);
  assign depth_m1  = depth_q - CNT_W'(1);
  assign room      = fill_q < CNT_W'(MAX_ITEMS);
  assign stk_room  = depth_q < CNT_W'(MAX_ITEMS);
  assign le        = $signed(rd_a_q) <= $signed(pivot_q);
  assign swap_needed = le && (place_q != j_q);
  assign emit_last = k_q == fill_m1[IDX_W-1:0];
  assign out_xfer  = out_valid_q && !out_stall_i;
  assign push_r_ok = ({1'b0, place_q} + RW'(1)) < {1'b0, high_q};
  assign push_l_ok = {1'b0, place_q} > ({1'b0, low_q} + RW'(1));
  assign len       = {1'b0, high_q} - {1'b0, low_q} + RW'(1);
  assign lfsr_nxt  = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? rqs_pkg::LFSR_TAPS : 32'd0);

  rqs_mod_unit #(.MAX_ITEMS(MAX_ITEMS)) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.op == rqs_pkg::OP_SPLIT),
    .dividend_i(lfsr_nxt),
    .divisor_i (len),
    .rem_o     (rem),
    .done_o    (mod_done)
  );

  // Key store ports.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sa_q;
    mem_wd = rd_b_q;
    mem_re = 1'b0;
    mem_ra = sa_q;
    mem_rb = sb_q;
    case (cmd_i.op)
      rqs_pkg::OP_LOAD: begin
        mem_we = room;
        mem_wa = fill_q[IDX_W-1:0];
        mem_wd = in_item_i.key_value;
      end
      rqs_pkg::OP_SW_RD:  mem_re = 1'b1;
      rqs_pkg::OP_SW_WA:  mem_we = 1'b1;
      rqs_pkg::OP_SW_WB: begin
        mem_we = 1'b1;
        mem_wa = sb_q;
        mem_wd = rd_a_q;
      end
      rqs_pkg::OP_LOOP_RD: begin
        mem_re = 1'b1;
        mem_ra = j_q;
        mem_rb = place_q;
      end
      rqs_pkg::OP_LOOP_CMP: begin
        mem_we = swap_needed;
        mem_wa = place_q;
        mem_wd = rd_a_q;
      end
      rqs_pkg::OP_LOOP_SW: begin
        mem_we = 1'b1;
        mem_wa = j_q;
      end
      rqs_pkg::OP_EM_RD: begin
        mem_re = 1'b1;
        mem_ra = k_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) keys[mem_wa] <= mem_wd;
    if (mem_re) begin
      rd_a_q <= keys[mem_ra];
      rd_b_q <= keys[mem_rb];
    end
  end

  // Range stack ports.
  always_comb begin
    stk_we = 1'b0;
    stk_wa = depth_q[IDX_W-1:0];
    stk_wd = {low_q, high_q};
    case (cmd_i.op)
      rqs_pkg::OP_START: begin
        stk_we = 1'b1;
        stk_wa = '0;
        stk_wd = {{IDX_W{1'b0}}, fill_m1[IDX_W-1:0]};
      end
      rqs_pkg::OP_PUSH_R: begin
        stk_we = push_r_ok && stk_room;
        stk_wd = {place_q + IDX_W'(1), high_q};
      end
      rqs_pkg::OP_PUSH_L: begin
        stk_we = push_l_ok && stk_room;
        stk_wd = {low_q, place_q - IDX_W'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stack[stk_wa] <= stk_wd;
    if (cmd_i.op == rqs_pkg::OP_POP) stk_rd_q <= stack[depth_m1[IDX_W-1:0]];
  end

  // Control state.
  always_comb begin
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    depth_d     = depth_q;
    lfsr_d      = lfsr_q;
    out_valid_d = out_valid_q && !out_xfer;
    case (cmd_i.op)
      rqs_pkg::OP_LOAD: begin
        if (room) fill_d = fill_q + CNT_W'(1);
        else      ovf_d  = 1'b1;
      end
      rqs_pkg::OP_START: begin
        cnt_d   = '0;
        depth_d = (fill_q >= CNT_W'(2)) ? CNT_W'(1) : CNT_W'(0);
      end
      rqs_pkg::OP_POP:      depth_d = depth_m1;
      rqs_pkg::OP_SPLIT:    lfsr_d  = lfsr_nxt;
      rqs_pkg::OP_LOOP_CMP: cnt_d   = cnt_q + CW'(1);
      rqs_pkg::OP_PUSH_R: if (push_r_ok && stk_room) depth_d = depth_q + CNT_W'(1);
      rqs_pkg::OP_PUSH_L: if (push_l_ok && stk_room) depth_d = depth_q + CNT_W'(1);
      rqs_pkg::OP_EM_OUT:   out_valid_d = 1'b1;
      rqs_pkg::OP_EM_NEXT: begin
        if (emit_last) begin
          fill_d  = '0;
          ovf_d   = 1'b0;
          cnt_d   = '0;
          depth_d = '0;
        end
      end
      default: ;
    endcase
    if (cfg_we_i) lfsr_d = (cfg_wdata_i != 32'd0) ? cfg_wdata_i : rqs_pkg::SEED_RESET;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      depth_q     <= '0;
      lfsr_q      <= rqs_pkg::SEED_RESET;
      seed_q      <= rqs_pkg::SEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      depth_q     <= depth_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) seed_q <= cfg_wdata_i;
    end
  end

  // Working indices, pivot and output payload.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rqs_pkg::OP_START: k_q <= '0;
      rqs_pkg::OP_RANGE: begin
        low_q  <= stk_rd_q[2*IDX_W-1:IDX_W];
        high_q <= stk_rd_q[IDX_W-1:0];
      end
      rqs_pkg::OP_PICK: begin
        sa_q <= low_q + rem;
        sb_q <= high_q;
      end
      rqs_pkg::OP_PART: begin
        pivot_q <= rd_a_q;
        place_q <= low_q;
        j_q     <= low_q;
      end
      rqs_pkg::OP_LOOP_CMP: begin
        if (le && !swap_needed) begin
          place_q <= place_q + IDX_W'(1);
          j_q     <= j_q + IDX_W'(1);
        end else if (!le) begin
          j_q <= j_q + IDX_W'(1);
        end
      end
      rqs_pkg::OP_LOOP_SW: begin
        place_q <= place_q + IDX_W'(1);
        j_q     <= j_q + IDX_W'(1);
      end
      rqs_pkg::OP_FIN: begin
        sa_q <= place_q;
        sb_q <= high_q;
      end
      rqs_pkg::OP_EM_OUT: begin
        out_q.sorted_key    <= rd_a_q;
        out_q.compare_total <= cnt_q;
        out_q.dropped_flag  <= ovf_q;
        out_q.final_item    <= emit_last;
      end
      rqs_pkg::OP_EM_NEXT: k_q <= k_q + IDX_W'(1);
      default: ;
    endcase
  end

  assign seed_o      = seed_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.depth_zero  = depth_q == '0;
  assign status_o.range_ok    = low_q < high_q;
  assign status_o.mod_done    = mod_done;
  assign status_o.j_at_high   = j_q == high_q;
  assign status_o.swap_needed = swap_needed;
  assign status_o.emit_last   = emit_last;
  assign status_o.out_xfer    = out_xfer;

endmodule

// ----- design/rqs_ctrl.sv -----
// Sequencer: loading, stack-driven partitioning and emission.
`timescale 1ns / 1ps
module rqs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_set_end_i,
  output logic                in_stall_o,
  input  rqs_pkg::dp_status_t status_i,
  output rqs_pkg::dp_cmd_t    cmd_o
);

  localparam logic [4:0] S_LOAD    = 5'd0;
  localparam logic [4:0] S_START   = 5'd1;
  localparam logic [4:0] S_POP     = 5'd2;
  localparam logic [4:0] S_RANGE   = 5'd3;
  localparam logic [4:0] S_CHECK   = 5'd4;
  localparam logic [4:0] S_MOD     = 5'd5;
  localparam logic [4:0] S_SW_RD   = 5'd6;
  localparam logic [4:0] S_SW_WA   = 5'd7;
  localparam logic [4:0] S_SW_WB   = 5'd8;
  localparam logic [4:0] S_PART    = 5'd9;
  localparam logic [4:0] S_LP_RD   = 5'd10;
  localparam logic [4:0] S_LP_CMP  = 5'd11;
  localparam logic [4:0] S_LP_SW   = 5'd12;
  localparam logic [4:0] S_PUSH_R  = 5'd13;
  localparam logic [4:0] S_PUSH_L  = 5'd14;
  localparam logic [4:0] S_EM_RD   = 5'd15;
  localparam logic [4:0] S_EM_OUT  = 5'd16;
  localparam logic [4:0] S_EM_WAIT = 5'd17;

  logic [4:0] state_q, state_d;
  logic       fin_q, fin_d;

  always_comb begin
    state_d   = state_q;
    fin_d     = fin_q;
    cmd_o.op  = rqs_pkg::OP_IDLE;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.op = rqs_pkg::OP_LOAD;
          if (in_set_end_i) state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.op = rqs_pkg::OP_START;
        state_d  = S_POP;
      end
      S_POP: begin
        if (status_i.depth_zero) begin
          state_d = S_EM_RD;
        end else begin
          cmd_o.op = rqs_pkg::OP_POP;
          state_d  = S_RANGE;
        end
      end
      S_RANGE: begin
        cmd_o.op = rqs_pkg::OP_RANGE;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (!status_i.range_ok) begin
          state_d = S_POP;
        end else begin
          cmd_o.op = rqs_pkg::OP_SPLIT;
          state_d  = S_MOD;
        end
      end
      S_MOD: begin
        if (status_i.mod_done) begin
          cmd_o.op = rqs_pkg::OP_PICK;
          fin_d    = 1'b0;
          state_d  = S_SW_RD;
        end
      end
      S_SW_RD: begin
        cmd_o.op = rqs_pkg::OP_SW_RD;
        state_d  = S_SW_WA;
      end
      S_SW_WA: begin
        cmd_o.op = rqs_pkg::OP_SW_WA;
        state_d  = S_SW_WB;
      end
      S_SW_WB: begin
        cmd_o.op = rqs_pkg::OP_SW_WB;
        state_d  = fin_q ? S_PUSH_R : S_PART;
      end
      S_PART: begin
        cmd_o.op = rqs_pkg::OP_PART;
        state_d  = S_LP_RD;
      end
      S_LP_RD: begin
        if (status_i.j_at_high) begin
          cmd_o.op = rqs_pkg::OP_FIN;
          fin_d    = 1'b1;
          state_d  = S_SW_RD;
        end else begin
          cmd_o.op = rqs_pkg::OP_LOOP_RD;
          state_d  = S_LP_CMP;
        end
      end
      S_LP_CMP: begin
        cmd_o.op = rqs_pkg::OP_LOOP_CMP;
        state_d  = status_i.swap_needed ? S_LP_SW : S_LP_RD;
      end
      S_LP_SW: begin
        cmd_o.op = rqs_pkg::OP_LOOP_SW;
        state_d  = S_LP_RD;
      end
      S_PUSH_R: begin
        cmd_o.op = rqs_pkg::OP_PUSH_R;
        state_d  = S_PUSH_L;
      end
      S_PUSH_L: begin
        cmd_o.op = rqs_pkg::OP_PUSH_L;
        state_d  = S_POP;
      end
      S_EM_RD: begin
        cmd_o.op = rqs_pkg::OP_EM_RD;
        state_d  = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd_o.op = rqs_pkg::OP_EM_OUT;
        state_d  = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (status_i.out_xfer) begin
          cmd_o.op = rqs_pkg::OP_EM_NEXT;
          state_d  = status_i.emit_last ? S_LOAD : S_EM_RD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  assign in_stall_o = state_q != S_LOAD;

endmodule

// ----- design/randomized_quicksort_counter_unit.sv -----
// Top level of the randomized quicksort unit with comparison counting.
`timescale 1ns / 1ps
// Keys stream in one per transfer and are stored until the transfer flagged
// set_end; keys beyond MAX_ITEMS are dropped and reported by dropped_flag.
// The set_end transfer starts a randomized Lomuto quicksort driven by an
// explicit range stack; the input stays stalled until the last sorted key
// has been taken. Each partition of a range pops the stack, checks the
// range, runs a bit-serial remainder that picks the pivot from the LFSR and
// swaps the pivot to the high end of the range; it then reads and compares
// each element, swaps an element that moves, places the pivot and pushes
// the halves. Emission reads each key, presents it and waits until it is
// taken before it reads another key. A full set of 64 keys needs about 42
// partitions and 360 comparisons. The key store is a single-write memory
// with two registered read ports, which sets the cost of each swap. The
// pivot LFSR (Galois, taps 0x80200003) reloads from pivot_seed on every
// write of that register (a zero seed loads 1) and otherwise keeps running
// across sets. pivot_seed lives at APB byte address 0; write it only while
// the unit waits for keys.
module randomized_quicksort_counter_unit #(
  parameter int unsigned MAX_ITEMS = rqs_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // key input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rqs_pkg::in_item_t  in_item_i,
  // sorted key channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rqs_pkg::out_item_t out_item_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  rqs_pkg::dp_cmd_t    cmd;
  rqs_pkg::dp_status_t status;
  logic [31:0]         seed;
  logic                cfg_we;

  // Register zero is the only one; the upper word is unmapped.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : seed;

  rqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_set_end_i(in_item_i.set_end),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rqs_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(pwdata),
    .seed_o     (seed),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .status_o   (status)
  );

endmodule

// ----- design/rqs_checker.sv -----
// Port-level checker for the quicksort unit and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rqs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input rqs_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rqs_pkg::out_item_t out_item_o
);

  `RQS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `RQS_ASSERT(a_load_no_output, clk_i, rst_ni, !in_stall_o |-> !out_valid_o)
  `RQS_ASSERT_NEXT(a_end_stalls, clk_i, rst_ni, in_valid_i && !in_stall_o && in_item_i.set_end, in_stall_o)
  `RQS_ASSERT_NEXT(a_final_drains, clk_i, rst_ni, out_valid_o && !out_stall_i && out_item_o.final_item, !out_valid_o && !in_stall_o)

endmodule

bind randomized_quicksort_counter_unit rqs_checker u_rqs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

// ----- bench/testbench.sv -----
// Self-checking testbench for the randomized quicksort counter unit.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned NKEYS = 64;
  localparam logic [2:0] ADDR_PIVOT_SEED = 3'd0;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  rqs_pkg::in_item_t in_item_i;
  rqs_pkg::out_item_t out_item_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  randomized_quicksort_counter_unit i_dut (.*);

  // Shadow state of the sorter, updated per accepted input transfer.
  logic signed [31:0] shadow_keys [NKEYS];
  int unsigned shadow_fill;
  logic shadow_dropped;
  logic [31:0] shadow_lfsr;
  logic [10:0] shadow_cmp;

  rqs_pkg::out_item_t sorted_queue [$];
  int unsigned error_count = 0;
  int unsigned sets_done = 0, keys_seen = 0;

  // Step the Galois LFSR once.
  function automatic logic [31:0] lfsr_step(logic [31:0] v);
    lfsr_step = v[0] ? ((v >> 1) ^ rqs_pkg::LFSR_TAPS) : (v >> 1);
  endfunction

  task automatic swap_shadow(int unsigned a, int unsigned b);
    logic signed [31:0] t;
    t = shadow_keys[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_keys[b] = t;
  endtask

  // Lomuto partition around a random pivot; returns the final pivot index.
  task automatic split_shadow(input int unsigned lo, input int unsigned hi,
                              output int unsigned place);
    int unsigned pick;
    logic signed [31:0] piv;
    shadow_lfsr = lfsr_step(shadow_lfsr);
    pick = lo + (shadow_lfsr % (hi - lo + 1));
    swap_shadow(pick, hi);
    piv = shadow_keys[hi];
    place = lo;
    for (int unsigned j = lo; j < hi; j++) begin
      shadow_cmp = shadow_cmp + 11'd1;
      if (shadow_keys[j] <= piv) begin
        swap_shadow(place, j);
        place++;
      end
    end
    swap_shadow(place, hi);
  endtask

  // Fold one key into the shadow state; on set end queue the sorted set.
  task automatic predict_sorted(rqs_pkg::in_item_t it);
    int unsigned ranges [$];
    int unsigned lo, hi, q, entry;
    if (shadow_fill < NKEYS) begin
      shadow_keys[shadow_fill] = it.key_value;
      shadow_fill++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (!it.set_end) return;
    shadow_cmp = '0;
    if (shadow_fill >= 2) ranges.push_back(shadow_fill - 1);
    while (ranges.size() > 0) begin
      entry = ranges.pop_back();
      lo = entry >> 6;
      hi = entry & 63;
      if (lo >= hi) continue;
      split_shadow(lo, hi, q);
      if (q + 1 < hi) ranges.push_back(((q + 1) << 6) | hi);
      if (q > lo + 1) ranges.push_back((lo << 6) | (q - 1));
    end
    for (int unsigned k = 0; k < shadow_fill; k++)
      sorted_queue.push_back('{sorted_key: shadow_keys[k], compare_total: shadow_cmp,
                               dropped_flag: shadow_dropped,
                               final_item: (k + 1 == shadow_fill)});
    shadow_fill = 0;
    shadow_dropped = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Limit: far beyond the slowest correct run.
  initial begin
    #200ms;
    $display("randomized_quicksort_counter_unit: mismatch");
    $finish;
  end

  // Random gap length: mostly short, occasionally long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) gap_len = 0;
    else if (r < 92) gap_len = $urandom_range(1, 3);
    else gap_len = $urandom_range(10, 40);
  endfunction

  // Output side: random stall and checking of every sorted transfer.
  initial begin
    int unsigned hold;
    rqs_pkg::out_item_t want;
    out_stall_i = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        keys_seen++;
        if (sorted_queue.size() == 0) begin
          $error("sorted key transfer with nothing expected: %0d", out_item_o.sorted_key);
          error_count++;
        end else begin
          want = sorted_queue.pop_front();
          if (out_item_o.sorted_key !== want.sorted_key) begin
            $error("sorted_key expected %0d actual %0d", want.sorted_key,
                   out_item_o.sorted_key);
            error_count++;
          end
          if (out_item_o.compare_total !== want.compare_total) begin
            $error("compare_total expected %0d actual %0d", want.compare_total,
                   out_item_o.compare_total);
            error_count++;
          end
          if (out_item_o.dropped_flag !== want.dropped_flag) begin
            $error("dropped_flag expected %0b actual %0b", want.dropped_flag,
                   out_item_o.dropped_flag);
            error_count++;
          end
          if (out_item_o.final_item !== want.final_item) begin
            $error("final_item expected %0b actual %0b", want.final_item,
                   out_item_o.final_item);
            error_count++;
          end
          if (want.final_item) sets_done++;
        end
      end
      // Hold stall for a random stretch, then release it.
      if (hold > 0) begin
        hold--;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        hold = $urandom_range(0, 6);
      end else begin
        hold = gap_len();
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          hold--;
        end
      end
    end
  end

  // Write pivot_seed through APB: setup cycle, then access cycle.
  task automatic write_pivot_seed(logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_PIVOT_SEED; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    shadow_lfsr = (value != 0) ? value : 32'd1;
    @(posedge clk_i);
    if (prdata !== value) begin
      $error("pivot_seed expected %0h actual %0h", value, prdata);
      error_count++;
    end
  endtask

  // Send one key; the expected results are formed when it is accepted.
  task automatic send_key(logic signed [31:0] key, logic last);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{key_value: key, set_end: last};
    do @(posedge clk_i); while (in_stall_o);
    predict_sorted('{key_value: key, set_end: last});
  endtask

  // Drop the input, wait until every sorted key has come, plus settle time.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sorted_queue.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] random_key(int unsigned mode);
    case (mode)
      0: random_key = $urandom;
      1: random_key = $urandom_range(0, 7) - 4;
      default: random_key = ($urandom_range(0, 1) ? 32'h7fff_fffc : 32'h8000_0000)
                            + $urandom_range(0, 3);
    endcase
  endfunction

  typedef struct {
    logic signed [31:0] key;
    logic last;
  } step_row_t;

  // Directed sets: one-key set, extremes, duplicates, a reverse run.
  step_row_t directed_rows [] = '{
    '{32'sh0000_0005, 1'b1},
    '{32'sh7fff_ffff, 1'b0}, '{32'sh8000_0000, 1'b0}, '{32'sh0000_0000, 1'b0},
    '{-32'sd1, 1'b1},
    '{32'sd3, 1'b0}, '{32'sd3, 1'b0}, '{32'sd3, 1'b1},
    '{32'sd9, 1'b0}, '{32'sd7, 1'b0}, '{32'sd5, 1'b0}, '{32'sd1, 1'b0},
    '{-32'sd5, 1'b1}
  };

  initial begin
    int unsigned n, mode, sent;
    in_valid_i = 1'b0;
    in_item_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    shadow_fill = 0; shadow_dropped = 1'b0; shadow_cmp = '0;
    shadow_lfsr = rqs_pkg::SEED_RESET;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A one-key set needs no partition: typed-in expectation.
    send_key(32'sd42, 1'b1);
    if (sorted_queue.size() != 1) begin
      $error("queued results expected 1 actual %0d", sorted_queue.size());
      error_count++;
    end else begin
      if (sorted_queue[0].sorted_key !== 32'sd42) begin
        $error("sorted_key expected 42 actual %0d", sorted_queue[0].sorted_key);
        error_count++;
      end
      if (sorted_queue[0].compare_total !== 11'd0) begin
        $error("compare_total expected 0 actual %0d", sorted_queue[0].compare_total);
        error_count++;
      end
      if (sorted_queue[0].final_item !== 1'b1) begin
        $error("final_item expected 1 actual %0b", sorted_queue[0].final_item);
        error_count++;
      end
    end
    foreach (directed_rows[i]) send_key(directed_rows[i].key, directed_rows[i].last);
    wait_drained();

    // Overflow: a full set plus extra keys, the last one dropped too.
    write_pivot_seed(32'hffff_ffff);
    for (int unsigned i = 0; i < NKEYS + 2; i++)
      send_key(random_key(0), i == NKEYS + 1);
    wait_drained();
    write_pivot_seed(32'd0);

    // Random sets; mostly small, a few full. Seed changes between phases.
    sent = 0;
    while (sent < 420) begin
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
        write_pivot_seed($urandom_range(0, 3) == 0 ? 32'd1 : $urandom);
      end
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
      mode = $urandom_range(0, 2);
      for (int unsigned i = 0; i < n; i++) send_key(random_key(mode), i == n - 1);
      sent += n;
    end
    wait_drained();

    $display("covered %0d sorted sets, %0d sorted keys, overflow and seed changes",
             sets_done, keys_seen);
    if (error_count == 0) begin
      $display("randomized_quicksort_counter_unit: match");
    end else begin
      $display("randomized_quicksort_counter_unit: mismatch");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+design
design/rqs_pkg.sv
design/rqs_mod_unit.sv
design/rqs_datapath.sv
design/rqs_ctrl.sv
design/randomized_quicksort_counter_unit.sv
design/rqs_checker.sv
bench/testbench.sv
